// File: design/msr_pkg.sv
// Shared types and constants for merge_sort_records.
// No dependencies; used by every module of the block but msr_ram.
`default_nettype none
package msr_pkg;

	localparam int MAX_ITEMS_DEF = 1024;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int KEY_W         = 32;
	localparam int REF_W         = 16;

	typedef struct packed {
		logic load;
		logic init;
		logic setup;
		logic merge;
		logic emit;
		logic capt;
		logic pop;
	} msr_cmd_t;

	typedef struct packed {
		logic need_sort;
		logic pair_last;
		logic pass_last;
		logic sort_last;
		logic fin;
	} msr_sts_t;

endpackage
`default_nettype wire

// File: design/msr_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module msr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule
`default_nettype wire

// File: design/msr_dp.sv
// Datapath of merge_sort_records: two ping-pong record banks, merge pointers,
// pass/run bookkeeping and the output register. Uses msr_pkg and msr_ram.
`default_nettype none
module msr_dp #(
	parameter int MAX_ITEMS = msr_pkg::MAX_ITEMS_DEF,
	parameter int KEY_WIDTH = msr_pkg::KEY_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire msr_pkg::msr_cmd_t          cmd,
	output msr_pkg::msr_sts_t               sts,
	input  wire logic [msr_pkg::KEY_W-1:0]  key,
	input  wire logic [msr_pkg::REF_W-1:0]  record_ref,
	output logic      [msr_pkg::KEY_W-1:0]  sorted_key,
	output logic      [msr_pkg::REF_W-1:0]  sorted_ref,
	output logic                            final_res,
	output logic                            overflow
);

	localparam int KW = (KEY_WIDTH < msr_pkg::KEY_W) ? KEY_WIDTH : msr_pkg::KEY_W;
	localparam int DW = KW + msr_pkg::REF_W;
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int PW = CW + 2;

	logic [CW-1:0] cnt_q, rptr_q;
	logic          drop_q, src_q;
	logic [PW-1:0] lo_q, wid_q;
	logic [PW-1:0] a_q, b_q, o_q, mid_q, hi_q;
	logic [PW-1:0] a_d, b_d;
	logic [PW-1:0] n_p, wid2, sum_mid, sum_hi, mid_c, hi_c;
	logic [DW-1:0] rd_a0, rd_a1, rd_b0, rd_b1, src0, src1, wdata_m, wdata_l;
	logic [DW-1:0] wdata_a;
	logic [AW-1:0] waddr_a, raddr0;
	logic          we_a, we_b, full, take_left, fin_c;
	logic [KW-1:0] out_key_q;
	logic [msr_pkg::REF_W-1:0] out_ref_q;
	logic          out_fin_q, out_ovf_q;

	assign n_p     = PW'(cnt_q);
	assign wid2    = wid_q << 1;
	assign sum_mid = lo_q + wid_q;
	assign sum_hi  = lo_q + wid2;
	assign mid_c   = (sum_mid > n_p) ? n_p : sum_mid;
	assign hi_c    = (sum_hi > n_p) ? n_p : sum_hi;
	assign full    = (cnt_q == CW'(MAX_ITEMS));

	assign src0 = src_q ? rd_b0 : rd_a0;
	assign src1 = src_q ? rd_b1 : rd_a1;

	always_comb begin
		if (a_q >= mid_q) begin
			take_left = 1'b0;
		end else if (b_q >= hi_q) begin
			take_left = 1'b1;
		end else begin
			take_left = (src0[DW-1:msr_pkg::REF_W] <= src1[DW-1:msr_pkg::REF_W]);
		end
	end

	always_comb begin
		a_d = a_q;
		b_d = b_q;
		if (cmd.setup) begin
			a_d = lo_q;
			b_d = mid_c;
		end else if (cmd.merge) begin
			if (take_left) begin
				a_d = a_q + PW'(1);
			end else begin
				b_d = b_q + PW'(1);
			end
		end
	end

	assign wdata_m = take_left ? src0 : src1;
	assign wdata_l = {key[KW-1:0], record_ref};
	assign we_a    = (cmd.load && !full) || (cmd.merge && src_q);
	assign we_b    = cmd.merge && !src_q;
	assign waddr_a = cmd.load ? cnt_q[AW-1:0] : o_q[AW-1:0];
	assign wdata_a = cmd.load ? wdata_l : wdata_m;
	assign raddr0  = cmd.emit ? rptr_q[AW-1:0] : a_d[AW-1:0];
	assign fin_c   = ({1'b0, rptr_q} + (CW + 1)'(1)) >= {1'b0, cnt_q};

	msr_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_bank_a (
		.clk    (clk),
		.we     (we_a),
		.waddr  (waddr_a),
		.wdata  (wdata_a),
		.raddr0 (raddr0),
		.raddr1 (b_d[AW-1:0]),
		.rdata0 (rd_a0),
		.rdata1 (rd_a1)
	);

	msr_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_bank_b (
		.clk    (clk),
		.we     (we_b),
		.waddr  (o_q[AW-1:0]),
		.wdata  (wdata_m),
		.raddr0 (raddr0),
		.raddr1 (b_d[AW-1:0]),
		.rdata0 (rd_b0),
		.rdata1 (rd_b1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			rptr_q <= '0;
			src_q  <= 1'b0;
			lo_q   <= '0;
			wid_q  <= '0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (cmd.init) begin
				lo_q  <= '0;
				wid_q <= PW'(1);
				src_q <= 1'b0;
			end
			if (cmd.merge && sts.pair_last) begin
				if (sts.pass_last) begin
					lo_q  <= '0;
					wid_q <= wid2;
					src_q <= !src_q;
				end else begin
					lo_q <= sum_hi;
				end
			end
			if (cmd.pop) begin
				if (out_fin_q) begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
					rptr_q <= '0;
				end else begin
					rptr_q <= rptr_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			mid_q <= mid_c;
			hi_q  <= hi_c;
			o_q   <= lo_q;
		end
		if (cmd.merge) begin
			o_q <= o_q + PW'(1);
		end
		a_q <= a_d;
		b_q <= b_d;
		if (cmd.capt) begin
			out_key_q <= src0[DW-1:msr_pkg::REF_W];
			out_ref_q <= src0[msr_pkg::REF_W-1:0];
			out_fin_q <= fin_c;
			out_ovf_q <= drop_q;
		end
	end

	assign sts.need_sort = (n_p > PW'(1));
	assign sts.pair_last = ((o_q + PW'(1)) == hi_q);
	assign sts.pass_last = (sum_hi >= n_p);
	assign sts.sort_last = (wid2 >= n_p);
	assign sts.fin       = out_fin_q;

	assign sorted_key = (msr_pkg::KEY_W)'(out_key_q);
	assign sorted_ref = out_ref_q;
	assign final_res  = out_fin_q;
	assign overflow   = out_ovf_q;

	a_merge_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> (o_q < hi_q))
		else $error("merge write beyond run end");
	a_merge_source: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> ((a_q < mid_q) || (b_q < hi_q)))
		else $error("merge with both runs exhausted");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("record count above capacity");
	a_rptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capt |-> (rptr_q < cnt_q))
		else $error("read pointer past stored records");

endmodule
`default_nettype wire

// File: design/msr_ctrl.sv
// Controller of merge_sort_records: load, sort-pass and drain sequencing.
// Uses msr_pkg command/status types; drives msr_dp.
`default_nettype none
module msr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output msr_pkg::msr_cmd_t      cmd,
	input  wire msr_pkg::msr_sts_t sts
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_MERGE = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_CAPT  = 3'd5;
	localparam logic [2:0] S_WAIT  = 3'd6;
	localparam logic [2:0] S_DRAIN = 3'd7;

	logic [2:0] state_q, state_d;

	assign in_ready  = (state_q == S_LOAD) || (state_q == S_DRAIN);
	assign out_valid = (state_q == S_WAIT);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == S_LOAD) && in_valid;
		cmd.init  = (state_q == S_INIT);
		cmd.setup = (state_q == S_SETUP);
		cmd.merge = (state_q == S_MERGE);
		cmd.emit  = (state_q == S_EMIT);
		cmd.capt  = (state_q == S_CAPT);
		cmd.pop   = (state_q == S_WAIT) && out_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_valid && last) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				state_d = sts.need_sort ? S_SETUP : S_EMIT;
			end
			S_SETUP: begin
				state_d = S_MERGE;
			end
			S_MERGE: begin
				if (sts.pair_last) begin
					state_d = (sts.pass_last && sts.sort_last) ? S_EMIT : S_SETUP;
				end
			end
			S_EMIT: begin
				state_d = S_CAPT;
			end
			S_CAPT: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (out_ready) begin
					state_d = sts.fin ? S_LOAD : S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (in_valid) begin
					state_d = S_EMIT;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.init, cmd.setup, cmd.merge, cmd.emit, cmd.capt, cmd.pop}))
		else $error("more than one datapath command");
	a_setup_merge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup |=> cmd.merge)
		else $error("setup not followed by merge");
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> ##1 out_valid)
		else $error("emit did not present a result");

endmodule
`default_nettype wire

// File: design/merge_sort_records.sv
// Top level of merge_sort_records: stable record sorter.
// Uses msr_pkg, msr_ctrl, msr_dp (which holds two msr_ram banks).
//
// Input channel (in_valid/in_ready, key, record_ref, last): records are
// stored one per cycle while loading. Records past MAX_ITEMS are dropped
// and every result of that set carries overflow. The transfer marked last
// ends the set, starts the sort and yields the first sorted record.
// Sort: ceil(log2 n) merge passes over n stored records after an init step,
// each run pair opened by a setup step; in_ready is low.
// Passes ping-pong between two banks; one write port per bank sets the
// pace of one merged record per cycle within a run pair.
// Output channel (out_valid/out_ready, sorted_key, sorted_ref, final_res,
// overflow): each later input transfer yields the next sorted record, its
// payload ignored. After such a transfer the result passes the EMIT and
// CAPT states before out_valid rises; after the transfer marked last the
// sort comes first. A result holds while the receiver stalls; no input
// is taken until it is taken.
// After final_res the block returns to loading with count and overflow clear.
// Reset (arst_n low) empties the store and returns to loading at once.
`default_nettype none
module merge_sort_records #(
	parameter int MAX_ITEMS = msr_pkg::MAX_ITEMS_DEF,
	parameter int KEY_WIDTH = msr_pkg::KEY_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [msr_pkg::KEY_W-1:0]  key,
	input  wire logic [msr_pkg::REF_W-1:0]  record_ref,
	input  wire logic                       last,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [msr_pkg::KEY_W-1:0]  sorted_key,
	output logic      [msr_pkg::REF_W-1:0]  sorted_ref,
	output logic                            final_res,
	output logic                            overflow
);

	msr_pkg::msr_cmd_t cmd;
	msr_pkg::msr_sts_t sts;

	msr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	msr_dp #(.MAX_ITEMS(MAX_ITEMS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.key        (key),
		.record_ref (record_ref),
		.sorted_key (sorted_key),
		.sorted_ref (sorted_ref),
		.final_res  (final_res),
		.overflow   (overflow)
	);

endmodule
`default_nettype wire

// File: tb/merge_sort_records_tb.sv
// Testbench for merge_sort_records: a directed table of record sets, then random sets
// and one set that overruns the store, each result checked in order against a stable sort.
// Depends on msr_pkg and the merge_sort_records RTL.
module merge_sort_records_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP              = msr_pkg::MAX_ITEMS_DEF;
	localparam int RANDOM_TRANSFERS = 1050;
	localparam int LIMIT_CYCLES     = 600000;
	localparam int TAIL_CYCLES      = 20;

	typedef logic [msr_pkg::KEY_W-1:0] key_t;
	typedef logic [msr_pkg::REF_W-1:0] ref_t;

	typedef struct packed {
		key_t k;
		ref_t r;
		logic fin;
		logic ovf;
	} sorted_rec_t;

	typedef struct packed {
		key_t        k;
		ref_t        r;
		logic        lst;
		logic        typed;
		sorted_rec_t want;
	} table_row_t;

	typedef enum int {KEYS_FULL, KEYS_TIED, KEYS_EDGE, KEYS_SHORT} key_style_t;

	// rows after a last mark pull out the sorted set; their payload is ignored
	localparam int DIRECTED_ROWS = 23;
	localparam table_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0}},
		'{32'h0000_0000, 16'h0000, 1'b1, 1'b1, '{32'h0000_0000, 16'h0000, 1'b1, 1'b0}},
		'{32'hFFFF_FFFF, 16'h0001, 1'b0, 1'b0, '0},
		'{32'h0000_0000, 16'h0002, 1'b0, 1'b0, '0},
		'{32'h8000_0000, 16'h0003, 1'b0, 1'b0, '0},
		'{32'h0000_0000, 16'h0004, 1'b1, 1'b1, '{32'h0000_0000, 16'h0002, 1'b0, 1'b0}},
		'{32'hDEAD_BEEF, 16'h5555, 1'b1, 1'b1, '{32'h0000_0000, 16'h0004, 1'b0, 1'b0}},
		'{32'h1234_5678, 16'hAAAA, 1'b0, 1'b1, '{32'h8000_0000, 16'h0003, 1'b0, 1'b0}},
		'{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 16'h0001, 1'b1, 1'b0}},
		'{32'h0000_0007, 16'h0010, 1'b0, 1'b0, '0},
		'{32'h0000_0007, 16'h0011, 1'b0, 1'b0, '0},
		'{32'h0000_0007, 16'h0012, 1'b0, 1'b0, '0},
		'{32'h0000_0007, 16'h0013, 1'b0, 1'b0, '0},
		'{32'h0000_0007, 16'h0014, 1'b1, 1'b0, '0},
		'{32'h0000_0000, 16'h0000, 1'b0, 1'b0, '0},
		'{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, '0},
		'{32'h0000_0005, 16'h0005, 1'b0, 1'b0, '0},
		'{32'hA5A5_A5A5, 16'h5A5A, 1'b1, 1'b0, '0},
		'{32'h0000_0003, 16'h0300, 1'b0, 1'b0, '0},
		'{32'h0000_0002, 16'h0200, 1'b0, 1'b0, '0},
		'{32'h0000_0001, 16'h0100, 1'b1, 1'b0, '0},
		'{32'h0F0F_0F0F, 16'hF0F0, 1'b0, 1'b0, '0},
		'{32'hF0F0_F0F0, 16'h0F0F, 1'b1, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	key_t key;
	ref_t record_ref;
	logic last;
	logic out_valid;
	logic out_ready;
	key_t sorted_key;
	ref_t sorted_ref;
	logic final_res;
	logic overflow;

	merge_sort_records dut (.*);

	key_t        held_key [CAP];
	ref_t        held_ref [CAP];
	int          held_count;
	bit          held_dropped;
	bit          unloading;
	int          next_out;
	sorted_rec_t pending_sorted [$];

	int fail_count;
	int sets_done;
	int records_stored;
	int n_in;
	int n_out;
	bit burst;
	bit pause_pending;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic key_t draw_key(key_style_t style);
		case (style)
			KEYS_TIED: return key_t'($urandom_range(0, 3));
			KEYS_SHORT: return key_t'($urandom >> $urandom_range(0, 31));
			KEYS_EDGE: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			default: return key_t'($urandom);
		endcase
	endfunction

	// stable: a record moves left only past strictly larger keys
	function automatic void sort_held();
		key_t tk;
		ref_t tr;
		int   i;
		int   j;
		for (i = 1; i < held_count; i++) begin
			tk = held_key[i];
			tr = held_ref[i];
			j  = i;
			while (j > 0 && held_key[j-1] > tk) begin
				held_key[j] = held_key[j-1];
				held_ref[j] = held_ref[j-1];
				j--;
			end
			held_key[j] = tk;
			held_ref[j] = tr;
		end
	endfunction

	function automatic void emit_sorted();
		sorted_rec_t rec;
		rec.k   = held_key[next_out];
		rec.r   = held_ref[next_out];
		rec.fin = (next_out + 1 >= held_count);
		rec.ovf = held_dropped;
		pending_sorted.push_back(rec);
		if (rec.fin) begin
			held_count   = 0;
			held_dropped = 1'b0;
			unloading    = 1'b0;
			next_out     = 0;
			sets_done++;
		end else begin
			next_out++;
		end
	endfunction

	function automatic void accept_record(key_t k, ref_t r, logic lst);
		if (unloading) begin
			emit_sorted();
		end else begin
			if (held_count < CAP) begin
				held_key[held_count] = k;
				held_ref[held_count] = r;
				held_count++;
				records_stored++;
			end else begin
				held_dropped = 1'b1;
			end
			if (lst) begin
				sort_held();
				unloading = 1'b1;
				next_out  = 0;
				emit_sorted();
			end
		end
	endfunction

	task automatic push_record(input key_t k, input ref_t r, input logic lst, input bit pause);
		int gap;
		gap = draw_gap();
		if (pause_pending) begin
			pause         = 1'b1;
			pause_pending = 1'b0;
		end
		if (pause && gap == 0)
			gap = 1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			while (pause && pending_sorted.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		key        <= k;
		record_ref <= r;
		last       <= lst;
		do
			@(posedge clk);
		while (!in_ready);
		n_in++;
		accept_record(k, r, lst);
	endtask

	task automatic run_set(input int n, input key_style_t style);
		int i;
		for (i = 0; i < n; i++)
			push_record(draw_key(style), ref_t'($urandom), i == n - 1, $urandom_range(0, 24) == 0);
		while (unloading)
			push_record(key_t'($urandom), ref_t'($urandom), 1'($urandom),
				$urandom_range(0, 24) == 0);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	initial begin
		int          stall;
		sorted_rec_t want;
		out_ready <= 1'b0;
		stall = draw_gap();
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				n_out++;
				if (pending_sorted.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected transfer, expected none, actual key %h ref %h",
						$time, sorted_key, sorted_ref);
				end else begin
					want = pending_sorted.pop_front();
					check_field("sorted_key", want.k, sorted_key);
					check_field("sorted_ref", want.r, sorted_ref);
					check_field("final_res", want.fin, final_res);
					check_field("overflow", want.ovf, overflow);
				end
				stall = draw_gap();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int         i;
		int         n;
		int         start_in;
		key_style_t style;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		key        <= '0;
		record_ref <= '0;
		last       <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			push_record(DIRECTED[i].k, DIRECTED[i].r, DIRECTED[i].lst, 1'b0);
			if (DIRECTED[i].typed)
				pending_sorted[pending_sorted.size() - 1] = DIRECTED[i].want;
		end

		pause_pending = 1'b1;
		start_in = n_in;
		while (n_in - start_in < RANDOM_TRANSFERS) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 19))
				0: n = $urandom_range(65, 200);
				1, 2, 3: n = $urandom_range(13, 64);
				default: n = $urandom_range(1, 12);
			endcase
			style = key_style_t'($urandom_range(0, 3));
			run_set(n, style);
		end

		// overrun the store; the last-marked record itself is dropped
		burst = 1'b1;
		run_set(CAP + 3, KEYS_FULL);
		burst = 1'b0;

		in_valid <= 1'b0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d sets (%0d records stored, %0d input and %0d output transfers),",
			sets_done, records_stored, n_in, n_out);
		$display("with tied keys, key extremes, single-record sets and a %0d-entry store overrun.",
			CAP);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
